FILE: rtl/mip_chain_box_downsampler_core_macros.svh
// Assertion macros shared by the mip chain downsampler RTL.
// Needs nothing else; files that assert include it by name.
`ifndef MIP_CHAIN_BOX_DOWNSAMPLER_CORE_MACROS_SVH
`define MIP_CHAIN_BOX_DOWNSAMPLER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MCBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mcbd_pkg.sv
// Shared constants, payload types and helpers of the mip chain downsampler.
// Depends on nothing; every module of the block refers to it by scoped names.
`default_nettype none

package mcbd_pkg;

  // Tile geometry. The extent is a power of two so every level splits evenly.
  localparam int TILE_EXTENT     = 64;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int MIP_LEVELS      = 6;

  localparam int NUM_CH      = BYTES_PER_PIXEL;
  localparam int CH_W        = 8;
  localparam int SUM_W       = CH_W + 1;
  localparam int COORD_W     = $clog2(TILE_EXTENT);
  localparam int POS_W       = 2 * COORD_W;
  localparam int HALF_W      = COORD_W - 1;
  localparam int STORE_DEPTH = TILE_EXTENT / 2;
  localparam int STORE_AW    = COORD_W - 1;
  localparam int LVL_IDX_W   = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
  localparam int LEVEL_W     = 3;

  // Result group queue, a power of two deep so the pointers wrap on their own.
  localparam int GQ_DEPTH = 4;
  localparam int GQ_AW    = $clog2(GQ_DEPTH);
  localparam int GQ_CW    = $clog2(GQ_DEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0] in_chan0;
    logic [CH_W-1:0] in_chan1;
    logic [CH_W-1:0] in_chan2;
    logic [CH_W-1:0] in_chan3;
  } in_pix_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] mip_level;
    logic [HALF_W-1:0]  out_row;
    logic [HALF_W-1:0]  out_col;
    logic [CH_W-1:0]    out_chan0;
    logic [CH_W-1:0]    out_chan1;
    logic [CH_W-1:0]    out_chan2;
    logic [CH_W-1:0]    out_chan3;
    logic               last_of_run;
  } out_res_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] psum_t;

  // Pixel handed from one level cell to the next, with its coordinates.
  typedef struct packed {
    logic               go;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    pix_t               pix;
  } link_t;

  // One finished mip pixel; its level is the slot position in the group.
  typedef struct packed {
    logic              valid;
    logic [HALF_W-1:0] row;
    logic [HALF_W-1:0] col;
    pix_t              pix;
  } slot_t;

  // All results caused by one base pixel, lowest level in slot 0.
  typedef struct packed {
    slot_t [MIP_LEVELS-1:0] slots;
  } grp_t;

  // Row store entries in use at a level: half as many at each level down.
  function automatic logic [STORE_AW-1:0] store_mask(input logic [LVL_IDX_W-1:0] lvl);
    return STORE_AW'((STORE_DEPTH >> lvl) - 1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mcbd_cell.sv
// One mip level of the chain: held left pixel, row pair store and 2x2 mean.
// Depends on mcbd_pkg; instantiated once per level by the top level.
`default_nettype none

module mcbd_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic [mcbd_pkg::LVL_IDX_W-1:0]  lvl_idx,
  input  wire mcbd_pkg::link_t                 link_i,
  input  wire mcbd_pkg::grp_t                  grp_i,
  output mcbd_pkg::link_t                      link_o,
  output mcbd_pkg::grp_t                       grp_o
);

  mcbd_pkg::pix_t                    held_r;
  mcbd_pkg::psum_t                   store_r [mcbd_pkg::STORE_DEPTH];
  mcbd_pkg::link_t                   link_r, link_nxt;
  mcbd_pkg::grp_t                    grp_r, grp_nxt;
  mcbd_pkg::psum_t                   pair;
  mcbd_pkg::psum_t                   rd;
  mcbd_pkg::pix_t                    mean;
  logic [mcbd_pkg::NUM_CH-1:0][mcbd_pkg::SUM_W+1:0] sum4;
  logic [mcbd_pkg::STORE_AW-1:0]     idx;
  logic                              is_right, is_odd_row, done;
  mcbd_pkg::slot_t                   slot;

  assign is_right   = link_i.col[0];
  assign is_odd_row = link_i.row[0];
  assign done       = link_i.go && is_right && is_odd_row;
  assign idx        = link_i.col[mcbd_pkg::COORD_W-1:1] & mcbd_pkg::store_mask(lvl_idx);
  assign rd         = store_r[idx];

  // Pair sum with the held left pixel, then the rounded mean of the block.
  always_comb begin
    for (int ch = 0; ch < mcbd_pkg::NUM_CH; ch++) begin
      pair[ch] = {1'b0, held_r[ch]} + {1'b0, link_i.pix[ch]};
      sum4[ch] = {2'b00, rd[ch]} + {2'b00, pair[ch]} + (mcbd_pkg::SUM_W + 2)'(2);
      mean[ch] = sum4[ch][mcbd_pkg::SUM_W:2];
    end
  end

  // The finished pixel goes to the next level at half resolution.
  always_comb begin
    link_nxt     = link_i;
    link_nxt.go  = done;
    link_nxt.row = {1'b0, link_i.row[mcbd_pkg::COORD_W-1:1]};
    link_nxt.col = {1'b0, link_i.col[mcbd_pkg::COORD_W-1:1]};
    link_nxt.pix = mean;

    slot.valid = done;
    slot.row   = link_i.row[mcbd_pkg::COORD_W-1:1];
    slot.col   = link_i.col[mcbd_pkg::COORD_W-1:1];
    slot.pix   = mean;

    grp_nxt                = grp_i;
    grp_nxt.slots[lvl_idx] = slot;
  end

  // Handoff registers toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.go <= 1'b0;
      for (int k = 0; k < mcbd_pkg::MIP_LEVELS; k++) begin
        grp_r.slots[k].valid <= 1'b0;
      end
    end else if (en) begin
      link_r <= link_nxt;
      grp_r  <= grp_nxt;
    end
  end

  // Level state: left pixels on even columns, pair sums on even rows.
  always_ff @(posedge clk) begin
    if (en && link_i.go && !is_right) begin
      held_r <= link_i.pix;
    end
    if (en && link_i.go && is_right && !is_odd_row) begin
      store_r[idx] <= pair;
    end
  end

  assign link_o = link_r;
  assign grp_o  = grp_r;

endmodule

`default_nettype wire

FILE: rtl/mcbd_grp_queue.sv
// Result group queue; serializer sends one result per cycle while out_ready.
// Depends on mcbd_pkg and the assertion macros header.
`default_nettype none

`include "mip_chain_box_downsampler_core_macros.svh"

module mcbd_grp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire mcbd_pkg::grp_t     grp_i,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mcbd_pkg::out_res_t      out_data
);

  mcbd_pkg::grp_t                 mem_r [mcbd_pkg::GQ_DEPTH];
  logic [mcbd_pkg::GQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [mcbd_pkg::GQ_CW-1:0]     cnt_r, cnt_nxt;
  logic [mcbd_pkg::LVL_IDX_W-1:0] k_r, k_nxt;
  logic                           out_valid_r, out_valid_nxt;
  mcbd_pkg::out_res_t             out_data_r, out_data_nxt;
  mcbd_pkg::grp_t                 head;
  mcbd_pkg::slot_t                cur;
  logic [mcbd_pkg::MIP_LEVELS:0]  vld_ext, vld_shift;
  logic                           load, emit, more, pop;

  assign full = (cnt_r == mcbd_pkg::GQ_CW'(mcbd_pkg::GQ_DEPTH));
  assign head = mem_r[rd_ptr_r];
  assign cur  = head.slots[k_r];

  // Valid slots of a group are contiguous from level one up.
  always_comb begin
    vld_ext = '0;
    for (int i = 0; i < mcbd_pkg::MIP_LEVELS; i++) begin
      vld_ext[i] = head.slots[i].valid;
    end
    vld_shift = vld_ext >> k_r;
  end

  assign load = !out_valid_r || out_ready;
  assign emit = load && (cnt_r != '0);
  assign more = vld_shift[1];
  assign pop  = emit && !more;

  // Pointer, count and slot walk.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + mcbd_pkg::GQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + mcbd_pkg::GQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + mcbd_pkg::GQ_CW'(push) - mcbd_pkg::GQ_CW'(pop);
    if (pop) begin
      k_nxt = '0;
    end else if (emit) begin
      k_nxt = k_r + mcbd_pkg::LVL_IDX_W'(1);
    end else begin
      k_nxt = k_r;
    end
  end

  // Output register, refilled whenever it is empty or being taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      out_data_nxt.mip_level   = mcbd_pkg::LEVEL_W'(k_r) + mcbd_pkg::LEVEL_W'(1);
      out_data_nxt.out_row     = cur.row;
      out_data_nxt.out_col     = cur.col;
      out_data_nxt.out_chan0   = cur.pix[0];
      out_data_nxt.out_chan1   = cur.pix[1];
      out_data_nxt.out_chan2   = cur.pix[2];
      out_data_nxt.out_chan3   = cur.pix[3];
      out_data_nxt.last_of_run = !more;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Group storage and output payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= grp_i;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MCBD_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full, "group pushed into a full queue")
  `MCBD_ASSERT_NOW(a_head_slot_valid, clk, rst_n, cnt_r != '0, cur.valid, "serializer on empty slot")
  `MCBD_ASSERT_NOW(a_walk_needs_group, clk, rst_n, k_r != '0, cnt_r != '0, "slot walk without group")
  `MCBD_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, pop, out_valid && out_data.last_of_run,
                    "group finished without a last result")

endmodule

`default_nettype wire

FILE: rtl/mip_chain_box_downsampler_core.sv
// 2x2 box filter mip chain builder for a 64x64 four-channel tile.
// Depends on mcbd_pkg, mcbd_cell and mcbd_grp_queue.
//
// Usage: base tile pixels enter on the in_ channel (valid/ready) in raster
// order, one pixel per request, and the position wraps to a new tile after the
// last pixel. Every pixel that closes 2x2 blocks yields one result request per
// completed level on the out_ channel, level one first, with last_of_run set
// on the deepest. Pixels that close nothing yield no result.
// Throughput: one input request per cycle while in_ready is high. A chain of
// six level cells, one register stage each, carries the results of a pixel
// along; they reach a four-group queue and leave one per cycle while out_ready
// is high, each through the queue's output register.
// When the receiver stalls the queue fills, and in_ready drops while the group
// at the end of the chain cannot be queued; the whole chain then holds.
// Reset clears the tile position and the queue. Held pixels and row sums need
// no clearing: raster order writes each before it is read.
`default_nettype none

module mip_chain_box_downsampler_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mcbd_pkg::in_pix_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mcbd_pkg::out_res_t       out_data
);

  logic [mcbd_pkg::POS_W-1:0] pos_r, pos_nxt;
  mcbd_pkg::link_t            links [mcbd_pkg::MIP_LEVELS+1];
  mcbd_pkg::grp_t             grps  [mcbd_pkg::MIP_LEVELS+1];
  logic                       adv, push, q_full, tail_busy;

  // The chain moves unless a finished group waits on a full queue.
  assign tail_busy = grps[mcbd_pkg::MIP_LEVELS].slots[0].valid;
  assign adv       = !(tail_busy && q_full);
  assign push      = adv && tail_busy;
  assign in_ready  = adv;

  // Raster position of the next base pixel; wraps at the tile size.
  assign pos_nxt = (in_valid && adv) ? pos_r + mcbd_pkg::POS_W'(1) : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Feed of the first level cell.
  always_comb begin
    links[0].go     = in_valid;
    links[0].row    = pos_r[mcbd_pkg::POS_W-1:mcbd_pkg::COORD_W];
    links[0].col    = pos_r[mcbd_pkg::COORD_W-1:0];
    links[0].pix[0] = in_data.in_chan0;
    links[0].pix[1] = in_data.in_chan1;
    links[0].pix[2] = in_data.in_chan2;
    links[0].pix[3] = in_data.in_chan3;
    grps[0]         = '0;
  end

  // One cell per mip level.
  for (genvar i = 0; i < mcbd_pkg::MIP_LEVELS; i++) begin : g_level
    mcbd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .lvl_idx (mcbd_pkg::LVL_IDX_W'(i)),
      .link_i  (links[i]),
      .grp_i   (grps[i]),
      .link_o  (links[i+1]),
      .grp_o   (grps[i+1])
    );
  end

  mcbd_grp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .grp_i     (grps[mcbd_pkg::MIP_LEVELS]),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
